@@ hw/rtl/config_line_lexer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the config line lexer
// Shared clocking and reset for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CONFIG_LINE_LEXER_ASSERT_SVH
`define CONFIG_LINE_LEXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("config_line_lexer check failed");

// next-cycle implication, sampled on clk, off during reset
`define CLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("config_line_lexer check failed");

`endif

@@ hw/rtl/cll_pkg.sv @@
// ----------------------------------------------------------------------------
// cll_pkg
// Types, constants and the byte classifier of the config line lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package cll_pkg;

	// longest line in columns; the column counter saturates here
	localparam int MAX_LINE_LENGTH = 256;
	localparam int COL_W           = $clog2(MAX_LINE_LENGTH + 1);

	typedef logic [COL_W-1:0] col_t;

	// required indentation columns
	localparam col_t COL_HYPHEN     = COL_W'(2);
	localparam col_t COL_LIST_SPACE = COL_W'(3);
	localparam col_t COL_KEY        = COL_W'(4);
	localparam col_t COL_MAX        = COL_W'(MAX_LINE_LENGTH);

	localparam logic [7:0] BYTE_LF = 8'h0A;

	// byte classes
	typedef enum logic [2:0] {
		CL_NEWLINE = 3'd0,
		CL_HASH    = 3'd1,
		CL_SPACE   = 3'd2,
		CL_HYPHEN  = 3'd3,
		CL_COLON   = 3'd4,
		CL_WORD    = 3'd5,
		CL_UNKNOWN = 3'd6
	} char_class_t;

	// per-line states
	typedef enum logic [7:0] {
		LS_START      = 8'b0000_0001,
		LS_COMMENT    = 8'b0000_0010,
		LS_INDENT     = 8'b0000_0100,
		LS_LIST_IND   = 8'b0000_1000,
		LS_CMD        = 8'b0001_0000,
		LS_CMD_SCALAR = 8'b0010_0000,
		LS_MAPPING    = 8'b0100_0000,
		LS_LIST_BLOCK = 8'b1000_0000
	} line_state_t;

	// reported line kinds
	localparam logic [2:0] KIND_EMPTY       = 3'd0;
	localparam logic [2:0] KIND_COMMENT     = 3'd1;
	localparam logic [2:0] KIND_CMD         = 3'd2;
	localparam logic [2:0] KIND_CMD_SCALAR  = 3'd3;
	localparam logic [2:0] KIND_MAPPING     = 3'd4;
	localparam logic [2:0] KIND_LIST_BLOCK  = 3'd5;
	localparam logic [2:0] KIND_LIST_SCALAR = 3'd6;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		cls = CL_UNKNOWN;
		if (c == BYTE_LF)                          cls = CL_NEWLINE;
		else if (c == "#")                         cls = CL_HASH;
		else if (c == " ")                         cls = CL_SPACE;
		else if (c == "-")                         cls = CL_HYPHEN;
		else if (c == ":")                         cls = CL_COLON;
		else if (c >= "0" && c <= "9")             cls = CL_WORD;
		else if (c >= "a" && c <= "z")             cls = CL_WORD;
		else if (c >= "A" && c <= "Z")             cls = CL_WORD;
		else if (c == "_" || c == "." || c == "/") cls = CL_WORD;
		return cls;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cll_byte_if.sv @@
// ----------------------------------------------------------------------------
// cll_byte_if
// Valid/ready channel that carries one text byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cll_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cll_line_if.sv @@
// ----------------------------------------------------------------------------
// cll_line_if
// Valid/ready channel that carries one line description per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cll_line_if;
	logic       valid;
	logic       ready;
	logic [2:0] line_kind;
	logic [7:0] key_start;
	logic [7:0] key_length;
	logic [7:0] value_start;
	logic [7:0] value_length;
	logic       syntax_error;

	modport source (
		output valid, output line_kind, output key_start, output key_length,
		output value_start, output value_length, output syntax_error,
		input ready
	);
	modport sink (
		input valid, input line_kind, input key_start, input key_length,
		input value_start, input value_length, input syntax_error,
		output ready
	);
endinterface

`default_nettype wire

@@ hw/rtl/config_line_lexer.sv @@
// A newline byte's line result is formed from the input byte register and held in the result register.
// Throughput: one byte per cycle unless a newline waits on a stalled result; the line
// state update is a single pass of logic between the input byte register and the line state registers.
// A stalled result blocks input only when a second newline reaches it.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// line state to start with column, key, value and error cleared.
// ----------------------------------------------------------------------------
// config_line_lexer
// Classifies text bytes, tracks per-line state and reports one result per
// line with its kind, key and value positions and a sticky error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module config_line_lexer
	import cll_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	cll_byte_if.sink      byte_in,
	cll_line_if.source    line_out
);

	// input byte register
	logic        valid_s1;
	logic [7:0]  ch_s1;

	// per-line state
	line_state_t state_q;
	col_t        column_q;
	col_t        key_begin_q;
	col_t        key_count_q;
	col_t        value_begin_q;
	logic        value_seen_q;
	logic        error_seen_q;

	// result register
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  key_start_q;
	logic [7:0]  key_length_q;
	logic [7:0]  value_start_q;
	logic [7:0]  value_length_q;
	logic        error_q;

	char_class_t cls;
	logic        is_nl;
	logic        adv_s1;

	line_state_t n_state;
	col_t        n_column;
	col_t        n_key_begin;
	col_t        n_key_count;
	col_t        n_value_begin;
	logic        n_value_seen;
	logic        n_error_seen;

	logic [2:0]  res_kind;
	col_t        res_key_count;
	logic        res_error;
	col_t        res_key_start;
	col_t        res_value_start;
	col_t        res_value_length;

	col_t        i;

	assign cls    = classify(ch_s1);
	assign is_nl  = (cls == CL_NEWLINE);
	assign i      = column_q;
	assign adv_s1 = valid_s1 && (!is_nl || !out_valid_q || line_out.ready);

	assign byte_in.ready = !valid_s1 || adv_s1;

	// capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			ch_s1 <= byte_in.ch;
		end
	end

	// advance the line state machine for one byte
	always_comb begin
		n_state       = state_q;
		n_column      = column_q;
		n_key_begin   = key_begin_q;
		n_key_count   = key_count_q;
		n_value_begin = value_begin_q;
		n_value_seen  = value_seen_q;
		n_error_seen  = error_seen_q;

		res_kind         = KIND_EMPTY;
		res_key_count    = key_count_q;
		res_error        = error_seen_q;
		res_key_start    = '0;
		res_value_start  = '0;
		res_value_length = '0;

		if (!is_nl) begin
			if (i >= COL_MAX) begin
				// line too long: flag and drop the byte
				n_error_seen = 1'b1;
			end else begin
				n_column = i + COL_W'(1);
				unique case (state_q)
					LS_START: begin
						if (i != '0) n_error_seen = 1'b1;
						case (cls)
							CL_HASH:  n_state = LS_COMMENT;
							CL_SPACE: n_state = LS_INDENT;
							CL_WORD: begin
								n_key_begin = i;
								n_state     = LS_CMD;
							end
							default:  n_error_seen = 1'b1;
						endcase
					end
					LS_COMMENT: begin
					end
					LS_INDENT: begin
						if (i > COL_KEY) n_error_seen = 1'b1;
						case (cls)
							CL_SPACE: begin
								if (i >= COL_KEY) n_error_seen = 1'b1;
							end
							CL_HYPHEN: begin
								if (i != COL_HYPHEN) n_error_seen = 1'b1;
								n_state = LS_LIST_IND;
							end
							CL_WORD: begin
								if (i != COL_KEY) n_error_seen = 1'b1;
								n_key_begin = i;
								n_state     = LS_MAPPING;
							end
							default: n_error_seen = 1'b1;
						endcase
					end
					LS_LIST_IND: begin
						if (i <= COL_HYPHEN || i > COL_KEY) n_error_seen = 1'b1;
						case (cls)
							CL_SPACE: begin
								if (i != COL_LIST_SPACE) n_error_seen = 1'b1;
							end
							CL_WORD: begin
								if (i != COL_KEY) n_error_seen = 1'b1;
								n_key_begin = i;
								n_state     = LS_LIST_BLOCK;
							end
							default: n_error_seen = 1'b1;
						endcase
					end
					LS_CMD: begin
						case (cls)
							CL_SPACE: begin
								if (key_count_q == '0) n_error_seen = 1'b1;
								n_state = LS_CMD_SCALAR;
							end
							CL_COLON: begin
								if (key_count_q != '0) n_error_seen = 1'b1;
								else n_key_count = i - key_begin_q;
							end
							CL_WORD: begin
								if (key_count_q != '0) n_error_seen = 1'b1;
							end
							default: n_error_seen = 1'b1;
						endcase
					end
					LS_CMD_SCALAR: begin
						if (cls == CL_WORD) begin
							if (!value_seen_q) begin
								n_value_begin = i;
								n_value_seen  = 1'b1;
							end
						end else begin
							n_error_seen = 1'b1;
						end
					end
					default: begin
						// mapping and list block share the key/value rules
						case (cls)
							CL_COLON: begin
								if (key_count_q != '0 || value_seen_q) n_error_seen = 1'b1;
								if (key_count_q == '0) n_key_count = i - key_begin_q;
							end
							CL_SPACE: begin
								if (key_count_q == '0 || value_seen_q) n_error_seen = 1'b1;
							end
							CL_WORD: begin
								if (!value_seen_q && key_count_q != '0) begin
									n_value_begin = i;
									n_value_seen  = 1'b1;
								end
							end
							default: n_error_seen = 1'b1;
						endcase
					end
				endcase
			end
		end else begin
			// end of line: settle the kind and final error
			unique case (state_q)
				LS_START:   res_kind = KIND_EMPTY;
				LS_COMMENT: res_kind = KIND_COMMENT;
				LS_INDENT, LS_LIST_IND: begin
					res_kind  = KIND_EMPTY;
					res_error = 1'b1;
				end
				LS_CMD: begin
					res_kind = KIND_CMD;
					if (key_count_q == '0) res_error = 1'b1;
				end
				LS_CMD_SCALAR: begin
					res_kind = KIND_CMD_SCALAR;
					if (!value_seen_q) res_error = 1'b1;
				end
				LS_MAPPING: begin
					res_kind = KIND_MAPPING;
					if (key_count_q == '0 || !value_seen_q) res_error = 1'b1;
				end
				default: begin
					if (value_seen_q) begin
						res_kind = KIND_LIST_BLOCK;
						if (key_count_q == '0) res_error = 1'b1;
					end else begin
						res_kind = KIND_LIST_SCALAR;
						if (key_count_q != '0) res_error = 1'b1;
						else res_key_count = i - key_begin_q;
					end
				end
			endcase
			if (res_key_count != '0) res_key_start = key_begin_q;
			if (value_seen_q) begin
				res_value_start  = value_begin_q;
				res_value_length = i - value_begin_q;
			end

			// clear for the next line
			n_state       = LS_START;
			n_column      = '0;
			n_key_begin   = '0;
			n_key_count   = '0;
			n_value_begin = '0;
			n_value_seen  = 1'b0;
			n_error_seen  = 1'b0;
		end
	end

	// hold the line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= LS_START;
			column_q      <= '0;
			key_begin_q   <= '0;
			key_count_q   <= '0;
			value_begin_q <= '0;
			value_seen_q  <= 1'b0;
			error_seen_q  <= 1'b0;
		end else if (adv_s1) begin
			state_q       <= n_state;
			column_q      <= n_column;
			key_begin_q   <= n_key_begin;
			key_count_q   <= n_key_count;
			value_begin_q <= n_value_begin;
			value_seen_q  <= n_value_seen;
			error_seen_q  <= n_error_seen;
		end
	end

	// result valid: set on a newline, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_nl) begin
			out_valid_q <= 1'b1;
		end else if (line_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_nl) begin
			kind_q         <= res_kind;
			key_start_q    <= res_key_start[7:0];
			key_length_q   <= res_key_count[7:0];
			value_start_q  <= res_value_start[7:0];
			value_length_q <= res_value_length[7:0];
			error_q        <= res_error;
		end
	end

	assign line_out.valid        = out_valid_q;
	assign line_out.line_kind    = kind_q;
	assign line_out.key_start    = key_start_q;
	assign line_out.key_length   = key_length_q;
	assign line_out.value_start  = value_start_q;
	assign line_out.value_length = value_length_q;
	assign line_out.syntax_error = error_q;

`include "config_line_lexer_assert.svh"

	`CLL_ASSERT_NOW(a_column_bound, 1'b1, column_q <= COL_MAX)
	`CLL_ASSERT_NEXT(a_line_cleared, adv_s1 && is_nl, state_q == LS_START && column_q == '0 && !error_seen_q)
	`CLL_ASSERT_NOW(a_stall_cause, valid_s1 && !byte_in.ready, out_valid_q && !line_out.ready)

endmodule

`default_nettype wire
